>>> design/vbdma_pkg.sv
// ----------------------------------------------------------------------------
// vbdma_pkg: shared types and constants of the VRAM block DMA controller
// Holds the action and command codes, the queue entry and the fixed sizes.
// ----------------------------------------------------------------------------
package vbdma_pkg;

  // Bytes moved by one blank event, and its shift amount.
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned CTRL_W   = 8;

  localparam logic [STATUS_W-1:0] STATUS_IDLE = 8'hFF;

  // Stream widths: tdata is padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;

  // Action codes as they arrive on the input stream.
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_CTRL   = 2'd1,
    ACT_BLANK  = 2'd2,
    ACT_STATUS = 2'd3
  } action_e;

  // Command kinds after classification by the front.
  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_IMM    = 3'd1,
    KIND_PACED  = 3'd2,
    KIND_BLANK  = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  // One queue entry.
  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [LEN_W-1:0]  len;
    logic [6:0]        blocks_m1;
  } cmd_t;

endpackage

>>> design/vram_block_dma_controller_core.sv
// ----------------------------------------------------------------------------
// vram_block_dma_controller_core: VRAM block DMA controller
// Turns pointer loads, control writes, blank events and status reads into
// copy descriptors and status reports, one result item per input item.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  tdata (low bit up)                       tuser
//   s_axis    in   source 16, dest 16, control 8            action 2
//   m_axis    out  source 16, dest 16, bytes 12, status 8,  copy_valid 1
//                  transfer_active 1, pad 3
//
// Every input item produces exactly one result item. The front decodes an
// item in the cycle it is accepted and writes it into the command queue;
// the back executes one queued command per cycle, while the output register
// is free, and registers its result there as it pops the queue head.
// The back sets the sustained rate of one item per cycle when unstalled.
// Reset clears the pointers and the byte count and sets status to 0xFF.
// A stalled output register stops the back; the front keeps accepting
// items until the queue of QUEUE_DEPTH entries is full.
//
module vram_block_dma_controller_core #(
  parameter int unsigned QUEUE_DEPTH = vbdma_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] source_address, [31:16] dest_address, [39:32] control_value
  input  logic [vbdma_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [vbdma_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] copy_source, [31:16] copy_dest, [43:32] copy_bytes,
  // [51:44] status_value, [52] transfer_active, [55:53] zero
  output logic [vbdma_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] copy_valid
  output logic                             m_axis_tuser_o
);

  // Commands travel from the decoder to the executor through the queue.
  vbdma_pkg::cmd_t push_cmd;
  vbdma_pkg::cmd_t head_cmd;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  vbdma_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (push),
    .q_cmd_o         (push_cmd)
  );

  vbdma_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  // The executor owns all transfer state and the output register.
  vbdma_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> design/vbdma_front.sv
// ----------------------------------------------------------------------------
// vbdma_front: input item decoder
// Splits an input item into its fields, classifies the action and computes
// the copy length for control writes.
// ----------------------------------------------------------------------------
module vbdma_front (
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [vbdma_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic [vbdma_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output vbdma_pkg::cmd_t                   q_cmd_o
);

  logic [vbdma_pkg::CTRL_W-1:0] ctrl;
  vbdma_pkg::action_e           action;

  assign action = vbdma_pkg::action_e'(s_axis_tuser_i);
  assign ctrl   = s_axis_tdata_i[39:32];

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_cmd_o.src       = s_axis_tdata_i[15:0];
    q_cmd_o.dst       = s_axis_tdata_i[31:16];
    q_cmd_o.blocks_m1 = ctrl[6:0];
    q_cmd_o.len       = (vbdma_pkg::LEN_W'(ctrl[6:0]) + vbdma_pkg::LEN_W'(1))
                        << vbdma_pkg::BLOCK_SHIFT;
    unique case (action)
      vbdma_pkg::ACT_LOAD:   q_cmd_o.kind = vbdma_pkg::KIND_LOAD;
      vbdma_pkg::ACT_CTRL:   q_cmd_o.kind = ctrl[7] ? vbdma_pkg::KIND_PACED
                                                    : vbdma_pkg::KIND_IMM;
      vbdma_pkg::ACT_BLANK:  q_cmd_o.kind = vbdma_pkg::KIND_BLANK;
      vbdma_pkg::ACT_STATUS: q_cmd_o.kind = vbdma_pkg::KIND_STATUS;
      default:               q_cmd_o.kind = vbdma_pkg::KIND_STATUS;
    endcase
  end

endmodule

>>> design/vbdma_queue.sv
// ----------------------------------------------------------------------------
// vbdma_queue: command queue between front and back
// A small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module vbdma_queue #(
  parameter int unsigned QUEUE_DEPTH = vbdma_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vbdma_pkg::cmd_t cmd_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output vbdma_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  vbdma_pkg::cmd_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> design/vbdma_back.sv
// ----------------------------------------------------------------------------
// vbdma_back: command executor
// Holds the pointers, the remaining byte count and the status byte; runs one
// queued command per cycle into its output register whenever that is free.
// ----------------------------------------------------------------------------
module vbdma_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  vbdma_pkg::cmd_t                  q_cmd_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [vbdma_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tuser_o
);

  localparam int unsigned AW = vbdma_pkg::ADDR_W;
  localparam int unsigned LW = vbdma_pkg::LEN_W;
  localparam int unsigned SW = vbdma_pkg::STATUS_W;

  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] dst_q, dst_d;
  logic [LW-1:0] remain_q, remain_d;
  logic [SW-1:0] status_q, status_d;

  logic          out_valid_q;
  logic          out_copy_q, copy;
  logic [AW-1:0] out_src_q, copy_src;
  logic [AW-1:0] out_dst_q, copy_dst;
  logic [LW-1:0] out_bytes_q, copy_bytes;
  logic [SW-1:0] out_status_q;
  logic          out_active_q;
  logic [LW-1:0] next_remain;
  logic [6:0]    left_m1;

  // The output register is free when empty or being taken this cycle.
  assign q_pop_o = !q_empty_i && (!out_valid_q || m_axis_tready_i);

  assign next_remain = (remain_q > LW'(vbdma_pkg::BLOCK_BYTES))
                       ? remain_q - LW'(vbdma_pkg::BLOCK_BYTES) : '0;
  // Blocks left minus one; the count never exceeds 128 blocks.
  assign left_m1 = remain_q[vbdma_pkg::BLOCK_SHIFT +: 7] - 7'd1;

  always_comb begin
    src_d      = src_q;
    dst_d      = dst_q;
    remain_d   = remain_q;
    status_d   = status_q;
    copy       = 1'b0;
    copy_bytes = '0;
    unique case (q_cmd_i.kind)
      vbdma_pkg::KIND_LOAD: begin
        src_d = q_cmd_i.src;
        dst_d = q_cmd_i.dst;
      end
      vbdma_pkg::KIND_IMM: begin
        if (remain_q != '0) begin
          // Cancel the running paced transfer and report what was left.
          status_d = {1'b1, left_m1};
          remain_d = '0;
        end else begin
          copy       = 1'b1;
          copy_bytes = q_cmd_i.len;
          status_d   = vbdma_pkg::STATUS_IDLE;
        end
      end
      vbdma_pkg::KIND_PACED: begin
        remain_d = q_cmd_i.len;
        status_d = {1'b0, q_cmd_i.blocks_m1};
      end
      vbdma_pkg::KIND_BLANK: begin
        if (remain_q != '0) begin
          copy       = 1'b1;
          copy_bytes = LW'(vbdma_pkg::BLOCK_BYTES);
          remain_d   = next_remain;
          status_d   = (next_remain == '0) ? vbdma_pkg::STATUS_IDLE
                                           : status_q - 1'b1;
        end
      end
      vbdma_pkg::KIND_STATUS: begin
      end
      default: begin
      end
    endcase
    copy_src = copy ? src_q : '0;
    copy_dst = copy ? dst_q : '0;
    if (copy) begin
      src_d = src_q + AW'(copy_bytes);
      dst_d = dst_q + AW'(copy_bytes);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      dst_q       <= '0;
      remain_q    <= '0;
      status_q    <= vbdma_pkg::STATUS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        src_q       <= src_d;
        dst_q       <= dst_d;
        remain_q    <= remain_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_copy_q   <= copy;
      out_src_q    <= copy_src;
      out_dst_q    <= copy_dst;
      out_bytes_q  <= copy_bytes;
      out_status_q <= status_d;
      out_active_q <= (remain_d != '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_copy_q;
  assign m_axis_tdata_o  = {3'b000, out_active_q, out_status_q, out_bytes_q,
                            out_dst_q, out_src_q};

  // The remaining count is always whole blocks.
  a_remain_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q[vbdma_pkg::BLOCK_SHIFT-1:0] == '0)
    else $error("remaining byte count is not a multiple of the block size");

  a_remain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= LW'(2048))
    else $error("remaining byte count above the largest transfer");

  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_copy_q) |->
      (out_bytes_q != '0) && (out_bytes_q[vbdma_pkg::BLOCK_SHIFT-1:0] == '0))
    else $error("copy result with a malformed byte count");

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> out_valid_q)
    else $error("executed command did not produce a result");

  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && copy && (remain_d == '0)) |=> (status_q == vbdma_pkg::STATUS_IDLE))
    else $error("status not idle after a finishing copy");

endmodule

>>> bench/vram_block_dma_controller_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_block_dma_controller_checker: result checker for the VRAM DMA core
// Watches both stream channels, keeps its own copy of the pointers, the
// remaining byte count and the status byte, and compares every result item
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module vram_block_dma_controller_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // [15:0] source_address, [31:16] dest_address, [39:32] control_value
  input  logic [vbdma_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [vbdma_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // [15:0] copy_source, [31:16] copy_dest, [43:32] copy_bytes,
  // [51:44] status_value, [52] transfer_active, [55:53] zero
  input  logic [vbdma_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  // [0] copy_valid
  input  logic                             m_axis_tuser_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);

  localparam int unsigned PACED_BIT = 7;
  localparam int unsigned AW        = vbdma_pkg::ADDR_W;
  localparam int unsigned LW        = vbdma_pkg::LEN_W;
  localparam int unsigned SW        = vbdma_pkg::STATUS_W;

  typedef struct packed {
    logic          copy_valid;
    logic [AW-1:0] src;
    logic [AW-1:0] dst;
    logic [LW-1:0] bytes;
    logic [SW-1:0] status;
    logic          active;
    logic [2:0]    pad;
  } dma_result_t;

  logic [AW-1:0] src_ptr;
  logic [AW-1:0] dst_ptr;
  logic [LW-1:0] bytes_left;
  logic [SW-1:0] status_reg;

  dma_result_t expected_results[$];
  dma_result_t got;
  dma_result_t want;
  int unsigned fails;
  int unsigned checked;

  // Builds a copy descriptor from the current pointers and moves them on.
  function automatic dma_result_t start_copy(logic [LW-1:0] nbytes);
    dma_result_t r;
    r            = '0;
    r.copy_valid = 1'b1;
    r.src        = src_ptr;
    r.dst        = dst_ptr;
    r.bytes      = nbytes;
    src_ptr      = src_ptr + AW'(nbytes);
    dst_ptr      = dst_ptr + AW'(nbytes);
    return r;
  endfunction

  function automatic dma_result_t predict_dma_result(vbdma_pkg::action_e act,
                                                     logic [AW-1:0] src_in,
                                                     logic [AW-1:0] dst_in,
                                                     logic [vbdma_pkg::CTRL_W-1:0] ctrl);
    dma_result_t   r;
    logic [LW-1:0] len;
    logic [SW-1:0] blocks_m1;
    r   = '0;
    len = LW'(({5'd0, ctrl[6:0]} + 12'd1) << vbdma_pkg::BLOCK_SHIFT);
    case (act)
      vbdma_pkg::ACT_LOAD: begin
        src_ptr = src_in;
        dst_ptr = dst_in;
      end
      vbdma_pkg::ACT_CTRL: begin
        if (!ctrl[PACED_BIT]) begin
          if (bytes_left != '0) begin
            // A running paced transfer is cancelled and reports what was left.
            blocks_m1  = SW'(bytes_left >> vbdma_pkg::BLOCK_SHIFT) - 8'd1;
            status_reg = blocks_m1 | 8'h80;
            bytes_left = '0;
          end else begin
            r          = start_copy(len);
            status_reg = vbdma_pkg::STATUS_IDLE;
          end
        end else begin
          bytes_left = len;
          status_reg = {1'b0, ctrl[6:0]};
        end
      end
      vbdma_pkg::ACT_BLANK: begin
        if (bytes_left != '0) begin
          r = start_copy(LW'(vbdma_pkg::BLOCK_BYTES));
          if (bytes_left > LW'(vbdma_pkg::BLOCK_BYTES))
            bytes_left = bytes_left - LW'(vbdma_pkg::BLOCK_BYTES);
          else bytes_left = '0;
          status_reg = status_reg - 8'd1;
          if (bytes_left == '0) status_reg = vbdma_pkg::STATUS_IDLE;
        end
      end
      default: ;
    endcase
    r.status = status_reg;
    r.active = (bytes_left != '0);
    return r;
  endfunction

  function automatic int unsigned field_mismatch(string name, logic [AW-1:0] want_v,
                                                 logic [AW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ptr    = '0;
      dst_ptr    = '0;
      bytes_left = '0;
      status_reg = vbdma_pkg::STATUS_IDLE;
      fails      = 0;
      checked    = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // Results are compared before the new item is predicted: the core registers
      // its result, so a result never belongs to this edge's input.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got            = '0;
        got.copy_valid = m_axis_tuser_i;
        got.src        = m_axis_tdata_i[15:0];
        got.dst        = m_axis_tdata_i[31:16];
        got.bytes      = m_axis_tdata_i[43:32];
        got.status     = m_axis_tdata_i[51:44];
        got.active     = m_axis_tdata_i[52];
        got.pad        = m_axis_tdata_i[55:53];
        if (expected_results.size() == 0) begin
          $error("result item arrived with no prediction waiting");
          fails++;
        end else begin
          want    = expected_results.pop_front();
          fails  += field_mismatch("copy_valid", 16'(want.copy_valid), 16'(got.copy_valid));
          fails  += field_mismatch("copy_source", want.src, got.src);
          fails  += field_mismatch("copy_dest", want.dst, got.dst);
          fails  += field_mismatch("copy_bytes", 16'(want.bytes), 16'(got.bytes));
          fails  += field_mismatch("status_value", 16'(want.status), 16'(got.status));
          fails  += field_mismatch("transfer_active", 16'(want.active), 16'(got.active));
          fails  += field_mismatch("tdata padding", 16'(want.pad), 16'(got.pad));
          checked++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(predict_dma_result(
                                     vbdma_pkg::action_e'(s_axis_tuser_i),
                                     s_axis_tdata_i[15:0],
                                     s_axis_tdata_i[31:16],
                                     s_axis_tdata_i[39:32]));
      end
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
      checked_o    <= checked;
    end
  end

endmodule

>>> bench/vram_block_dma_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_block_dma_controller_core_tb: stimulus and verdict for the VRAM DMA core
// Drives directed corner cases, then random runs of pointer loads, immediate
// copies and paced transfers with random idling on both channels, while the
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module vram_block_dma_controller_core_tb;

  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned CALM_ITEMS     = 100;
  localparam int unsigned DRAIN_EVERY    = 200;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic        PACED          = 1'b1;
  localparam logic        IMMEDIATE      = 1'b0;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [vbdma_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [vbdma_pkg::IN_USER_W-1:0]  s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [vbdma_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned items_sent;
  int unsigned items_counted;
  int unsigned gap_pct;
  int unsigned idle_cycles;
  logic        calm;

  vram_block_dma_controller_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  vram_block_dma_controller_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // 12 ns clock period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The watchdog restarts whenever either channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("vram_block_dma_controller_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stalls in bursts, with a stall rate picked anew for each phase;
  // a phase may pick no stalls, so some stretches run without any stall at all.
  initial begin : result_sink
    int unsigned stall_pct;
    int unsigned stall_len;
    int unsigned phase_cycles;
    m_axis_tready = 1'b0;
    stall_pct     = 0;
    phase_cycles  = 0;
    forever begin
      @(negedge clk_i);
      if (phase_cycles == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
        phase_cycles = 50;
      end
      phase_cycles--;
      if (!calm && rst_ni && ($urandom_range(0, 99) < stall_pct)) begin
        stall_len = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Presents one item at a falling edge and holds it until it is accepted.
  // The sender may first go idle for a burst of cycles.
  task automatic send_item(vbdma_pkg::action_e act, logic [15:0] src, logic [15:0] dst,
                           logic [7:0] ctrl, logic counted);
    int unsigned gap;
    if (!calm && ($urandom_range(0, 99) < gap_pct)) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ctrl, dst, src};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (counted) items_counted++;
  endtask

  // Drops tvalid and waits until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_addr();
    if ($urandom_range(0, 3) == 0) return 16'hFFFF - 16'($urandom_range(0, 64));
    return 16'($urandom);
  endfunction

  // Paced runs are mostly short, so each random sequence gets to its end.
  function automatic logic [6:0] pick_blocks();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 7));
  endfunction

  task automatic paced_sequence();
    logic [6:0]  blocks;
    int unsigned left;
    int unsigned roll;
    blocks = pick_blocks();
    send_item(vbdma_pkg::ACT_CTRL, rand_addr(), rand_addr(), {PACED, blocks}, 1'b1);
    left = blocks + 1;
    while (left > 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_item(vbdma_pkg::ACT_STATUS, rand_addr(), rand_addr(), 8'($urandom), 1'b1);
      end else if (roll < 10) begin
        send_item(vbdma_pkg::ACT_LOAD, rand_addr(), rand_addr(), 8'($urandom), 1'b1);
      end else if (roll < 14) begin
        // An immediate write in the middle of the run cancels it.
        send_item(vbdma_pkg::ACT_CTRL, rand_addr(), rand_addr(),
                  {IMMEDIATE, 7'($urandom)}, 1'b1);
        left = 0;
      end else if (roll < 17) begin
        blocks = pick_blocks();
        send_item(vbdma_pkg::ACT_CTRL, rand_addr(), rand_addr(), {PACED, blocks}, 1'b1);
        left = blocks + 1;
      end else begin
        send_item(vbdma_pkg::ACT_BLANK, rand_addr(), rand_addr(), 8'($urandom), 1'b1);
        left--;
      end
    end
    // A blank event after the end does nothing, so it is not counted.
    if ($urandom_range(0, 3) == 0)
      send_item(vbdma_pkg::ACT_BLANK, rand_addr(), rand_addr(), 8'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    int unsigned scenario;
    int unsigned next_drain;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = vbdma_pkg::ACT_LOAD;
    items_sent    = 0;
    items_counted = 0;
    gap_pct       = 0;
    calm          = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corner cases, starting from the reset state.
    gap_pct = 20;
    send_item(vbdma_pkg::ACT_STATUS, 16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);  // idle, ignored
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h00, 1'b1);  // smallest copy
    send_item(vbdma_pkg::ACT_LOAD,   16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h7F, 1'b1);  // largest, wraps
    send_item(vbdma_pkg::ACT_LOAD,   16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h80, 1'b1);  // one-block run
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);  // finishes it
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'hFF, 1'b1);  // longest run
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(vbdma_pkg::ACT_STATUS, 16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(vbdma_pkg::ACT_LOAD,   16'hFFF8, 16'h1FF0, 8'h00, 1'b1);  // keeps the run
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);  // source wraps
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h55, 1'b1);  // cancel mid-run
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);  // idle again
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h83, 1'b1);
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h81, 1'b1);  // re-arm replaces
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(vbdma_pkg::ACT_BLANK,  16'h0000, 16'h0000, 8'h00, 1'b1);  // past the end
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'hFF, 1'b1);
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h00, 1'b1);  // cancel full run
    send_item(vbdma_pkg::ACT_CTRL,   16'h0000, 16'h0000, 8'h7F, 1'b1);
    send_item(vbdma_pkg::ACT_LOAD,   16'h5A5A, 16'hA5A5, 8'h80, 1'b1);

    // Random part: mostly well-formed paced runs, plus copies and noise.
    items_counted = 0;
    next_drain    = DRAIN_EVERY;
    while (items_counted < RANDOM_ITEMS) begin
      if (items_counted >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      scenario = $urandom_range(0, 9);
      case (scenario)
        0, 1:    send_item(vbdma_pkg::ACT_LOAD, rand_addr(), rand_addr(),
                           8'($urandom), 1'b1);
        2, 3:    send_item(vbdma_pkg::ACT_CTRL, rand_addr(), rand_addr(),
                           {IMMEDIATE, 7'($urandom)}, 1'b1);
        8:       send_item(vbdma_pkg::ACT_STATUS, rand_addr(), rand_addr(),
                           8'($urandom), 1'b1);
        9:       send_item(vbdma_pkg::action_e'($urandom_range(0, 3)),
                           16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
        default: paced_sequence();
      endcase
      if (items_counted >= next_drain) begin
        // Hold the sender back until the core has answered everything.
        drain_results();
        next_drain += DRAIN_EVERY;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered pointer loads, immediate copies, paced runs with cancels and re-arms,");
    $display("blank events and status reads: %0d items sent, %0d results compared.",
             items_sent, checked);
    if (fail_count == 0) begin
      $display("vram_block_dma_controller_core: match");
    end else begin
      $display("vram_block_dma_controller_core: mismatch");
    end
    $finish;
  end

endmodule
